/* rtl/core/pit_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

  // Default sizes
  localparam int MAX_COLORS_DEF      = 256;
  localparam int MAX_TILES_DEF       = 4096;
  localparam int MAX_WIDTH_TILES_DEF = 256;

  // Palette limit while two indices share a byte
  localparam int NIBBLE_COLORS = 16;

  // Linear pixel index width, wide enough for any register setting
  localparam int PIX_W = 24;

  // Register indexes on the config port
  localparam logic [1:0] CFG_WIDTH_TILES = 2'd0;
  localparam logic [1:0] CFG_TILE_COUNT  = 2'd1;
  localparam logic [1:0] CFG_FOUR_BIT    = 2'd2;

  // Tile memory write kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_LOW_NIB  = 2'd1;
  localparam logic [1:0] KIND_HIGH_NIB = 2'd2;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [31:0] pixel_color;
  } pit_in_t;

  typedef struct packed {
    logic        in_range;
    logic [17:0] byte_address;
    logic [1:0]  write_kind;
    logic [7:0]  color_index;
    logic        new_color;
    logic [14:0] palette_word;
    logic        palette_overflow;
  } pit_out_t;

  // Broadcast from the controller to every palette cell
  typedef struct packed {
    logic        start;
    logic        clear;
    logic        wr_en;
    logic [31:0] probe;
  } pit_cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_SEARCH,
    S_ALLOC,
    S_DONE
  } pit_state_e;

  // 5:5:5 from the top bits of red, green, blue
  function automatic logic [14:0] pack_555(input logic [31:0] c);
    return {c[23:19], c[15:11], c[7:3]};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pit_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module pit_cell (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  pit_pkg::pit_cell_ctrl_t ctrl_i,
  input  wire                     tok_i,
  input  wire                     wr_sel_i,
  output logic                    tok_o,
  output logic                    hit_o
);
  import pit_pkg::*;

  logic        tok_q;
  logic [31:0] key_q;

  // Search token moves one cell per cycle until the controller clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  // Stored palette key
  always_ff @(posedge clk_i) begin
    if (wr_sel_i) begin
      key_q <= ctrl_i.probe;
    end
  end

  assign tok_o = tok_q;
  assign hit_o = tok_q && (key_q == ctrl_i.probe);

endmodule

`default_nettype wire

/* rtl/core/pit_chain.sv */
`timescale 1ns / 1ps
`default_nettype none

module pit_chain #(
  parameter int MAX_COLORS = pit_pkg::MAX_COLORS_DEF,
  localparam int IW = $clog2(MAX_COLORS)
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  pit_pkg::pit_cell_ctrl_t ctrl_i,
  input  wire [IW-1:0]            wr_idx_i,
  output logic                    any_hit_o
);
  import pit_pkg::*;

  logic [MAX_COLORS-1:0] tok;
  logic [MAX_COLORS-1:0] hit;

  // Row of palette cells, token handed left to right
  for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
    logic tok_in;
    logic sel;

    if (i == 0) begin : g_head
      assign tok_in = ctrl_i.start;
    end else begin : g_body
      assign tok_in = tok[i-1];
    end

    assign sel = ctrl_i.wr_en && (wr_idx_i == IW'(i));

    pit_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl_i),
      .tok_i    (tok_in),
      .wr_sel_i (sel),
      .tok_o    (tok[i]),
      .hit_o    (hit[i])
    );
  end

  assign any_hit_o = |hit;

  // Only one search in flight
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok))
    else $error("more than one search token in the cell row");

endmodule

`default_nettype wire

/* rtl/core/palette_indexer_tile_packer_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Handshake              | Word
// in      | in  | in_valid_i/in_ready_o  | pit_in_t: pixel_x, pixel_y, pixel_color
// out     | out | out_valid_o/out_ready_i | pit_out_t: one word per pixel
// cfg     | in  | cfg_we_i               | cfg_idx_i selects register, cfg_data_i
//
// One pixel at a time, through the multiply and address states; then a skipped
// pixel goes to done, a known color searches and goes to done, and a new color or
// a palette overflow searches (not for an empty palette), allocates, then is done.
// The search token steps one cell per cycle, to the hit or through the fill.
// Reset empties the palette, puts the registers at width 1, tile count 0, 8 bpp,
// and clears the search token.
// The output register holds a finished word while the next pixel is taken in;
// a pixel waits in the done state while that register is still occupied.
module palette_indexer_tile_packer_top #(
  parameter int MAX_COLORS      = pit_pkg::MAX_COLORS_DEF,
  parameter int MAX_TILES       = pit_pkg::MAX_TILES_DEF,
  parameter int MAX_WIDTH_TILES = pit_pkg::MAX_WIDTH_TILES_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  pit_pkg::pit_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output pit_pkg::pit_out_t out_data_o,
  input  wire               cfg_we_i,
  input  wire [1:0]         cfg_idx_i,
  input  wire [12:0]        cfg_data_i
);
  import pit_pkg::*;

  localparam int IW   = $clog2(MAX_COLORS);
  localparam int UW   = $clog2(MAX_COLORS + 1);
  localparam int CAP4 = (MAX_COLORS > NIBBLE_COLORS) ? NIBBLE_COLORS : MAX_COLORS;

  pit_state_e state_q, state_d;

  logic [8:0]       cfg_width_q;
  logic [12:0]      cfg_tiles_q;
  logic             cfg_four_q;
  pit_in_t          pix_in_q;
  logic [16:0]      prod_q;
  logic [PIX_W-1:0] pix_q;
  logic [UW-1:0]    used_q;
  logic [IW-1:0]    pos_q;
  pit_out_t         res_q, res_d;
  pit_out_t         out_q;
  logic             out_valid_q;

  logic             in_acc;
  logic             out_free;
  logic             any_hit;
  logic [8:0]       wt;
  logic [12:0]      tc;
  logic [PIX_W-1:0] pix;
  logic [PIX_W-1:0] pix_lim;
  logic             skip;
  logic             last_cell;
  logic [UW-1:0]    cap;
  logic             can_alloc;
  logic [17:0]      addr_sel;
  logic [1:0]       kind_sel;
  logic             res_load;
  logic             out_load;
  logic             used_inc;
  logic             pos_clr;
  logic             pos_inc;
  pit_cell_ctrl_t   cell_ctrl;

  // Clamped register views
  assign wt = (32'(cfg_width_q) > 32'(MAX_WIDTH_TILES)) ? 9'(MAX_WIDTH_TILES) : cfg_width_q;
  assign tc = (32'(cfg_tiles_q) > 32'(MAX_TILES)) ? 13'(MAX_TILES) : cfg_tiles_q;

  // Tile order pixel index and range check
  assign pix = PIX_W'({prod_q, 6'b0}) + PIX_W'({pix_in_q.pixel_x[10:3], 6'b0})
             + PIX_W'({pix_in_q.pixel_y[2:0], pix_in_q.pixel_x[2:0]});
  assign pix_lim = PIX_W'({tc, 6'b0});
  assign skip    = (pix >= pix_lim);

  // Tile memory write shape
  assign addr_sel = cfg_four_q ? pix_q[18:1] : pix_q[17:0];
  assign kind_sel = !cfg_four_q ? KIND_BYTE : (pix_q[0] ? KIND_HIGH_NIB : KIND_LOW_NIB);

  assign last_cell = ((UW'(pos_q) + UW'(1)) == used_q);
  assign cap       = cfg_four_q ? UW'(CAP4) : UW'(MAX_COLORS);
  assign can_alloc = (used_q < cap);

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_ADDR;
      end
      S_ADDR: begin
        if (skip) begin
          state_d = S_DONE;
        end else if (used_q == '0) begin
          state_d = S_ALLOC;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (any_hit) begin
          state_d = S_DONE;
        end else if (last_cell) begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs and result word
  always_comb begin
    in_ready_o      = 1'b0;
    res_load        = 1'b0;
    out_load        = 1'b0;
    used_inc        = 1'b0;
    pos_clr         = 1'b0;
    pos_inc         = 1'b0;
    res_d           = '0;
    cell_ctrl       = '0;
    cell_ctrl.probe = pix_in_q.pixel_color;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_ADDR: begin
        if (skip) begin
          res_load = 1'b1;
        end else if (used_q != '0) begin
          cell_ctrl.start = 1'b1;
          pos_clr         = 1'b1;
        end
      end
      S_SEARCH: begin
        if (any_hit) begin
          cell_ctrl.clear   = 1'b1;
          res_load          = 1'b1;
          res_d.in_range    = 1'b1;
          res_d.byte_address = addr_sel;
          res_d.write_kind  = kind_sel;
          res_d.color_index = 8'(pos_q);
        end else if (last_cell) begin
          cell_ctrl.clear = 1'b1;
        end else begin
          pos_inc = 1'b1;
        end
      end
      S_ALLOC: begin
        res_load           = 1'b1;
        res_d.in_range     = 1'b1;
        res_d.byte_address = addr_sel;
        res_d.write_kind   = kind_sel;
        if (can_alloc) begin
          cell_ctrl.wr_en    = 1'b1;
          used_inc           = 1'b1;
          res_d.color_index  = 8'(used_q);
          res_d.new_color    = 1'b1;
          res_d.palette_word = pack_555(pix_in_q.pixel_color);
        end else begin
          res_d.palette_overflow = 1'b1;
        end
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Palette cell row
  pit_chain #(
    .MAX_COLORS (MAX_COLORS)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cell_ctrl),
    .wr_idx_i  (used_q[IW-1:0]),
    .any_hit_o (any_hit)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_width_q <= 9'd1;
      cfg_tiles_q <= '0;
      cfg_four_q  <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH_TILES: cfg_width_q <= cfg_data_i[8:0];
          CFG_TILE_COUNT:  cfg_tiles_q <= cfg_data_i;
          CFG_FOUR_BIT:    cfg_four_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (used_inc) used_q <= used_q + UW'(1);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) pix_in_q <= in_data_i;
    if (state_q == S_MUL) prod_q <= 17'(wt * pix_in_q.pixel_y[10:3]);
    if (state_q == S_ADDR) pix_q <= pix;
    if (pos_clr) begin
      pos_q <= '0;
    end else if (pos_inc) begin
      pos_q <= pos_q + IW'(1);
    end
    if (res_load) res_q <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= MAX_COLORS)
    else $error("palette fill above capacity");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(used_q) |-> (used_q == $past(used_q) + UW'(1)))
    else $error("palette fill moved by other than one");

  a_new_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.new_color) |->
      (out_data_o.in_range && !out_data_o.palette_overflow))
    else $error("new color reported with overflow or out of range");

  a_hit_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_hit |-> (state_q == S_SEARCH))
    else $error("palette hit outside search");

endmodule

`default_nettype wire
